FILE: rtl/core/midi_track_event_parser_macros.svh
// Assertion macros for the MIDI track event parser RTL, included by mtep_core.
`ifndef MIDI_TRACK_EVENT_PARSER_MACROS_SVH
`define MIDI_TRACK_EVENT_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MTEP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mtep assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MTEP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mtep assertion failed");

`endif

FILE: rtl/core/mtep_pkg.sv
// Types, codes and helpers for the MIDI track event parser.
package mtep_pkg;

  typedef enum logic [2:0] {
    KIND_NOTE    = 3'd0,
    KIND_TEMPO   = 3'd1,
    KIND_END     = 3'd2,
    KIND_IGNORED = 3'd3,
    KIND_UNSUPP  = 3'd4
  } kind_e;

  typedef enum logic [7:0] {
    PH_DELTA     = 8'b0000_0001,
    PH_STATUS    = 8'b0000_0010,
    PH_CHAN_DATA = 8'b0000_0100,
    PH_META_CODE = 8'b0000_1000,
    PH_META_LEN  = 8'b0001_0000,
    PH_TEMPO     = 8'b0010_0000,
    PH_SKIP      = 8'b0100_0000,
    PH_SYSEX_LEN = 8'b1000_0000
  } phase_e;

  localparam logic       OP_DATA      = 1'b0;
  localparam logic       OP_RESTART   = 1'b1;
  localparam logic [7:0] ST_META      = 8'hFF;
  localparam logic [7:0] ST_SYSEX     = 8'hF0;
  localparam logic [7:0] ST_SYSEX_ESC = 8'hF7;
  localparam logic [7:0] META_TEMPO   = 8'h51;
  localparam logic [7:0] META_EOT     = 8'h2F;

  typedef struct packed {
    logic        emit;
    kind_e       kind;
    logic [31:0] delta_ticks;
    logic [7:0]  note_number;
    logic [7:0]  velocity;
    logic [3:0]  channel;
    logic [31:0] tempo_value;
  } res_t;

  // Program change and channel pressure (0xC0..0xDF) carry one data byte.
  function automatic logic one_byte_class(input logic [7:0] st);
    return st[7:5] == 3'b110;
  endfunction

endpackage

FILE: rtl/core/midi_track_event_parser.sv
// Top level of the MIDI track event parser: input register, decoder, result register.
// A completing byte is held in the input register, decoded, then its result is registered.
// Throughput: one byte per cycle; the decode state machine updates once per byte.
// The input side stalls only while the result register holds an untaken result.
// rst_ni (low, async) clears valid flags and decoder state; a restart clears the decoder.
module midi_track_event_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [31:0] delta_ticks_o,
  output logic [7:0]  note_number_o,
  output logic [7:0]  velocity_o,
  output logic [3:0]  channel_o,
  output logic [31:0] tempo_value_o
);

  logic           adv;
  logic           can_load;
  logic           op_q;
  logic [7:0]     byte_q;
  mtep_pkg::res_t res;

  mtep_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .data_byte_i (data_byte_i),
    .adv_ready_i (can_load),
    .adv_o       (adv),
    .op_o        (op_q),
    .data_byte_o (byte_q)
  );

  mtep_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .op_i        (op_q),
    .data_byte_i (byte_q),
    .res_o       (res)
  );

  mtep_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .res_i         (res),
    .can_load_o    (can_load),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .kind_o        (kind_o),
    .delta_ticks_o (delta_ticks_o),
    .note_number_o (note_number_o),
    .velocity_o    (velocity_o),
    .channel_o     (channel_o),
    .tempo_value_o (tempo_value_o)
  );

endmodule

FILE: rtl/core/mtep_in_stage.sv
// Input register stage: holds one byte transaction for the decode logic.
module mtep_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       op_i,
  input  logic [7:0] data_byte_i,
  input  logic       adv_ready_i,
  output logic       adv_o,
  output logic       op_o,
  output logic [7:0] data_byte_o
);

  logic       valid_q;
  logic       op_q;
  logic [7:0] byte_q;

  assign adv_o       = valid_q && adv_ready_i;
  assign in_stall_o  = valid_q && !adv_ready_i;
  assign op_o        = op_q;
  assign data_byte_o = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      op_q   <= op_i;
      byte_q <= data_byte_i;
    end
  end

endmodule

FILE: rtl/core/mtep_core.sv
// Event decode state machine: one byte per cycle while adv_i is high, at most one result per byte.
`include "midi_track_event_parser_macros.svh"

module mtep_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  logic          op_i,
  input  logic [7:0]    data_byte_i,
  output mtep_pkg::res_t res_o
);

  mtep_pkg::phase_e phase_q, phase_d;
  logic [7:0]  running_q, running_d;
  logic [31:0] len_q, len_d;
  logic [31:0] delta_q, delta_d;
  logic [31:0] bytes_q, bytes_d;
  logic [7:0]  eff_q, eff_d;
  logic [7:0]  meta_q, meta_d;
  logic [7:0]  first_q, first_d;
  logic [31:0] tempo_q, tempo_d;
  logic        ended_q, ended_d;

  logic        fin;
  logic [31:0] len_shift;
  logic [31:0] bytes_dec;
  logic [31:0] tempo_shift;
  logic [7:0]  b;

  assign b           = data_byte_i;
  assign len_shift   = {len_q[24:0], b[6:0]};
  assign bytes_dec   = bytes_q - 32'd1;
  assign tempo_shift = {tempo_q[23:0], b};

  always_comb begin
    phase_d   = phase_q;
    running_d = running_q;
    len_d     = len_q;
    delta_d   = delta_q;
    bytes_d   = bytes_q;
    eff_d     = eff_q;
    meta_d    = meta_q;
    first_d   = first_q;
    tempo_d   = tempo_q;
    ended_d   = ended_q;
    fin       = 1'b0;
    res_o.emit        = 1'b0;
    res_o.kind        = mtep_pkg::KIND_IGNORED;
    res_o.delta_ticks = delta_q;
    res_o.note_number = 8'd0;
    res_o.velocity    = 8'd0;
    res_o.channel     = 4'd0;
    res_o.tempo_value = 32'd0;

    if (adv_i) begin
      if (op_i == mtep_pkg::OP_RESTART) begin
        phase_d   = mtep_pkg::PH_DELTA;
        running_d = 8'd0;
        len_d     = 32'd0;
        delta_d   = 32'd0;
        bytes_d   = 32'd0;
        eff_d     = 8'd0;
        meta_d    = 8'd0;
        first_d   = 8'd0;
        tempo_d   = 32'd0;
        ended_d   = 1'b0;
      end else if (!ended_q) begin
        unique case (phase_q)
          mtep_pkg::PH_DELTA: begin
            delta_d = {delta_q[24:0], b[6:0]};
            if (!b[7]) phase_d = mtep_pkg::PH_STATUS;
          end
          mtep_pkg::PH_STATUS: begin
            if (b == mtep_pkg::ST_META) begin
              phase_d = mtep_pkg::PH_META_CODE;
            end else if (b == mtep_pkg::ST_SYSEX || b == mtep_pkg::ST_SYSEX_ESC) begin
              len_d   = 32'd0;
              phase_d = mtep_pkg::PH_SYSEX_LEN;
            end else if (b[7]) begin
              eff_d     = b;
              running_d = b;
              bytes_d   = mtep_pkg::one_byte_class(b) ? 32'd1 : 32'd2;
              phase_d   = mtep_pkg::PH_CHAN_DATA;
            end else begin
              // running status: this byte is already the first data byte
              eff_d   = running_q;
              first_d = b;
              if (mtep_pkg::one_byte_class(running_q)) begin
                fin = 1'b1;
              end else begin
                bytes_d = 32'd1;
                phase_d = mtep_pkg::PH_CHAN_DATA;
              end
            end
          end
          mtep_pkg::PH_CHAN_DATA: begin
            if (bytes_q >= 32'd2) begin
              first_d = b;
              bytes_d = 32'd1;
            end else if (eff_q[7:5] == 3'b100) begin
              fin               = 1'b1;
              res_o.kind        = mtep_pkg::KIND_NOTE;
              res_o.note_number = first_q;
              res_o.velocity    = eff_q[4] ? b : 8'd0;
              res_o.channel     = eff_q[3:0];
            end else begin
              fin = 1'b1;
            end
          end
          mtep_pkg::PH_META_CODE: begin
            meta_d  = b;
            len_d   = 32'd0;
            phase_d = mtep_pkg::PH_META_LEN;
          end
          mtep_pkg::PH_META_LEN: begin
            len_d = len_shift;
            if (!b[7]) begin
              if (meta_q == mtep_pkg::META_TEMPO) begin
                tempo_d = 32'd0;
                bytes_d = len_shift;
                if (len_shift == 32'd0) begin
                  fin        = 1'b1;
                  res_o.kind = mtep_pkg::KIND_TEMPO;
                end else begin
                  phase_d = mtep_pkg::PH_TEMPO;
                end
              end else if (meta_q == mtep_pkg::META_EOT) begin
                ended_d    = 1'b1;
                fin        = 1'b1;
                res_o.kind = mtep_pkg::KIND_END;
              end else if (!meta_q[7]) begin
                bytes_d = len_shift;
                if (len_shift == 32'd0) fin = 1'b1;
                else phase_d = mtep_pkg::PH_SKIP;
              end else begin
                fin        = 1'b1;
                res_o.kind = mtep_pkg::KIND_UNSUPP;
              end
            end
          end
          mtep_pkg::PH_SYSEX_LEN: begin
            len_d = len_shift;
            if (!b[7]) begin
              bytes_d = len_shift;
              if (len_shift == 32'd0) fin = 1'b1;
              else phase_d = mtep_pkg::PH_SKIP;
            end
          end
          mtep_pkg::PH_TEMPO: begin
            tempo_d = tempo_shift;
            bytes_d = bytes_dec;
            if (bytes_dec == 32'd0) begin
              fin               = 1'b1;
              res_o.kind        = mtep_pkg::KIND_TEMPO;
              res_o.tempo_value = tempo_shift;
            end
          end
          mtep_pkg::PH_SKIP: begin
            bytes_d = bytes_dec;
            if (bytes_dec == 32'd0) fin = 1'b1;
          end
          default: begin
            phase_d = mtep_pkg::PH_DELTA;
          end
        endcase
        if (fin) begin
          res_o.emit = 1'b1;
          phase_d    = mtep_pkg::PH_DELTA;
          delta_d    = 32'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= mtep_pkg::PH_DELTA;
      running_q <= 8'd0;
      len_q     <= 32'd0;
      delta_q   <= 32'd0;
      bytes_q   <= 32'd0;
      eff_q     <= 8'd0;
      meta_q    <= 8'd0;
      first_q   <= 8'd0;
      tempo_q   <= 32'd0;
      ended_q   <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      running_q <= running_d;
      len_q     <= len_d;
      delta_q   <= delta_d;
      bytes_q   <= bytes_d;
      eff_q     <= eff_d;
      meta_q    <= meta_d;
      first_q   <= first_d;
      tempo_q   <= tempo_d;
      ended_q   <= ended_d;
    end
  end

  `MTEP_ASSERT_NXT(a_restart_clears, clk_i, rst_ni,
    adv_i && op_i == mtep_pkg::OP_RESTART,
    phase_q == mtep_pkg::PH_DELTA && !ended_q && running_q == 8'd0)
  `MTEP_ASSERT_NXT(a_end_sets_flag, clk_i, rst_ni,
    res_o.emit && res_o.kind == mtep_pkg::KIND_END, ended_q)
  `MTEP_ASSERT_NXT(a_emit_clears_delta, clk_i, rst_ni,
    res_o.emit, delta_q == 32'd0 && phase_q == mtep_pkg::PH_DELTA)
  `MTEP_ASSERT_IMP(a_no_result_after_end, clk_i, rst_ni, ended_q, !res_o.emit)

endmodule

FILE: rtl/core/mtep_out_stage.sv
// Result register: holds one event result until the consumer takes it.
module mtep_out_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  mtep_pkg::res_t res_i,
  output logic           can_load_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [2:0]     kind_o,
  output logic [31:0]    delta_ticks_o,
  output logic [7:0]     note_number_o,
  output logic [7:0]     velocity_o,
  output logic [3:0]     channel_o,
  output logic [31:0]    tempo_value_o
);

  logic           valid_q;
  mtep_pkg::res_t res_q;

  assign can_load_o    = !valid_q || !out_stall_i;
  assign out_valid_o   = valid_q;
  assign kind_o        = res_q.kind;
  assign delta_ticks_o = res_q.delta_ticks;
  assign note_number_o = res_q.note_number;
  assign velocity_o    = res_q.velocity;
  assign channel_o     = res_q.channel;
  assign tempo_value_o = res_q.tempo_value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (can_load_o) begin
      valid_q <= adv_i && res_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_load_o && adv_i && res_i.emit) begin
      res_q <= res_i;
    end
  end

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for midi_track_event_parser: directed table, then random track streams.
module testbench;
  import mtep_pkg::*;

  localparam logic [7:0] ST_NOTE_OFF  = 8'h80;
  localparam logic [7:0] ST_NOTE_ON   = 8'h90;
  localparam logic [7:0] ST_NOTE_LAST = 8'h9F;
  localparam logic [7:0] ST_ONE_FIRST = 8'hC0;
  localparam logic [7:0] ST_ONE_LAST  = 8'hDF;
  localparam logic [7:0] ST_CHAN_MISC = 8'hA0;
  localparam logic [7:0] ST_SYS_LAST  = 8'hFE;
  localparam int unsigned DATA_ITEMS  = 1750;
  localparam int unsigned MAX_CYCLES  = 1_000_000;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] delta;
    logic [7:0]  note;
    logic [7:0]  vel;
    logic [3:0]  chan;
    logic [31:0] tempo;
  } evt_t;

  typedef struct packed {
    bit   typed;
    bit   has;
    evt_t ev;
  } hint_t;

  typedef struct {
    logic        op;
    logic [7:0]  b;
    bit          typed;
    bit          has;
    kind_e       kind;
    logic [31:0] delta;
    logic [7:0]  note;
    logic [7:0]  vel;
    logic [3:0]  chan;
    logic [31:0] tempo;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        op = OP_DATA;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  kind;
  logic [31:0] delta_ticks;
  logic [7:0]  note_number;
  logic [7:0]  velocity;
  logic [3:0]  channel;
  logic [31:0] tempo_value;

  midi_track_event_parser dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .op_i         (op),
    .data_byte_i  (data_byte),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .kind_o       (kind),
    .delta_ticks_o(delta_ticks),
    .note_number_o(note_number),
    .velocity_o   (velocity),
    .channel_o    (channel),
    .tempo_value_o(tempo_value)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Parser state mirror
  phase_e      ph = PH_DELTA;
  logic [7:0]  run_st, eff_st, meta_cd, param1;
  logic [31:0] len_acc, delta_acc, remaining, tempo_acc;
  bit          ended;

  evt_t        pending_events[$];
  hint_t       cur_hint = '0;
  int unsigned mismatches = 0;
  int unsigned data_items = 0;
  int unsigned calm_left = 0;
  int unsigned stall_cnt = 0;
  logic [7:0]  gen_run_st = 8'h00;

  function automatic void clear_parser();
    ph        = PH_DELTA;
    run_st    = '0;
    eff_st    = '0;
    meta_cd   = '0;
    param1    = '0;
    len_acc   = '0;
    delta_acc = '0;
    remaining = '0;
    tempo_acc = '0;
    ended     = 1'b0;
  endfunction

  function automatic bit single_param(input logic [7:0] st);
    return st >= ST_ONE_FIRST && st <= ST_ONE_LAST;
  endfunction

  function automatic evt_t close_event(input kind_e k, input logic [7:0] note,
                                       input logic [7:0] vel, input logic [3:0] ch,
                                       input logic [31:0] tempo);
    evt_t ev;
    ev.kind  = k;
    ev.delta = delta_acc;
    ev.note  = note;
    ev.vel   = vel;
    ev.chan  = ch;
    ev.tempo = tempo;
    ph        = PH_DELTA;
    delta_acc = '0;
    return ev;
  endfunction

  // Advances the mirror by one byte; returns 1 when an event completes.
  function automatic bit decode_track_byte(input logic op_in, input logic [7:0] b,
                                           output evt_t ev);
    bit got;
    got = 1'b0;
    ev  = '0;
    if (op_in == OP_RESTART) begin
      clear_parser();
    end else if (!ended) begin
      case (ph)
        PH_DELTA: begin
          delta_acc = {delta_acc[24:0], b[6:0]};
          if (!b[7]) ph = PH_STATUS;
        end
        PH_STATUS: begin
          if (b == ST_META) begin
            ph = PH_META_CODE;
          end else if (b == ST_SYSEX || b == ST_SYSEX_ESC) begin
            len_acc = '0;
            ph = PH_SYSEX_LEN;
          end else if (b[7]) begin
            eff_st = b;
            run_st = b;
            remaining = single_param(b) ? 32'd1 : 32'd2;
            ph = PH_CHAN_DATA;
          end else begin
            // running status, possibly the empty one after reset
            eff_st = run_st;
            param1 = b;
            if (single_param(eff_st)) begin
              ev = close_event(KIND_IGNORED, '0, '0, '0, '0);
              got = 1'b1;
            end else begin
              remaining = 32'd1;
              ph = PH_CHAN_DATA;
            end
          end
        end
        PH_CHAN_DATA: begin
          if (remaining >= 32'd2) begin
            param1 = b;
            remaining = 32'd1;
          end else if (eff_st >= ST_NOTE_OFF && eff_st <= ST_NOTE_LAST) begin
            ev = close_event(KIND_NOTE, param1, (eff_st >= ST_NOTE_ON) ? b : 8'h00,
                             eff_st[3:0], '0);
            got = 1'b1;
          end else begin
            ev = close_event(KIND_IGNORED, '0, '0, '0, '0);
            got = 1'b1;
          end
        end
        PH_META_CODE: begin
          meta_cd = b;
          len_acc = '0;
          ph = PH_META_LEN;
        end
        PH_META_LEN: begin
          len_acc = {len_acc[24:0], b[6:0]};
          if (!b[7]) begin
            if (meta_cd == META_TEMPO) begin
              tempo_acc = '0;
              remaining = len_acc;
              if (remaining == 0) begin
                ev = close_event(KIND_TEMPO, '0, '0, '0, '0);
                got = 1'b1;
              end else begin
                ph = PH_TEMPO;
              end
            end else if (meta_cd == META_EOT) begin
              ended = 1'b1;
              ev = close_event(KIND_END, '0, '0, '0, '0);
              got = 1'b1;
            end else if (!meta_cd[7]) begin
              remaining = len_acc;
              if (remaining == 0) begin
                ev = close_event(KIND_IGNORED, '0, '0, '0, '0);
                got = 1'b1;
              end else begin
                ph = PH_SKIP;
              end
            end else begin
              // high meta codes: payload is left in the stream
              ev = close_event(KIND_UNSUPP, '0, '0, '0, '0);
              got = 1'b1;
            end
          end
        end
        PH_SYSEX_LEN: begin
          len_acc = {len_acc[24:0], b[6:0]};
          if (!b[7]) begin
            remaining = len_acc;
            if (remaining == 0) begin
              ev = close_event(KIND_IGNORED, '0, '0, '0, '0);
              got = 1'b1;
            end else begin
              ph = PH_SKIP;
            end
          end
        end
        PH_TEMPO: begin
          tempo_acc = {tempo_acc[23:0], b};
          remaining = remaining - 32'd1;
          if (remaining == 0) begin
            ev = close_event(KIND_TEMPO, '0, '0, '0, tempo_acc);
            got = 1'b1;
          end
        end
        PH_SKIP: begin
          remaining = remaining - 32'd1;
          if (remaining == 0) begin
            ev = close_event(KIND_IGNORED, '0, '0, '0, '0);
            got = 1'b1;
          end
        end
        default: ph = PH_DELTA;
      endcase
    end
    return got;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < 50) $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Transaction monitor: predict on accepted bytes, compare accepted results.
  always @(posedge clk) begin
    evt_t ev;
    evt_t want;
    bit   produced;
    if (rst_n && in_valid && !in_stall) begin
      produced = decode_track_byte(op, data_byte, ev);
      if (cur_hint.typed) begin
        produced = cur_hint.has;
        ev = cur_hint.ev;
      end
      if (produced) pending_events.insert(pending_events.size(), ev);
    end
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d", kind));
      end else begin
        want = pending_events.pop_front();
        if (kind !== want.kind)
          report_mismatch($sformatf("kind got %0d want %0d", kind, want.kind));
        if (delta_ticks !== want.delta)
          report_mismatch($sformatf("delta_ticks got %h want %h", delta_ticks, want.delta));
        if (note_number !== want.note)
          report_mismatch($sformatf("note_number got %h want %h", note_number, want.note));
        if (velocity !== want.vel)
          report_mismatch($sformatf("velocity got %h want %h", velocity, want.vel));
        if (channel !== want.chan)
          report_mismatch($sformatf("channel got %h want %h", channel, want.chan));
        if (tempo_value !== want.tempo)
          report_mismatch($sformatf("tempo_value got %h want %h", tempo_value, want.tempo));
      end
    end
  end

  // Result-side backpressure: short stalls mostly, some long, calm stretches.
  always @(negedge clk) begin
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (stall_cnt != 0) begin
      stall_cnt--;
    end else if (out_stall) begin
      out_stall <= 1'b0;
      stall_cnt = (pick < 10) ? $urandom_range(100, 300) : $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b1;
      stall_cnt = (pick < 80) ? $urandom_range(0, 2) :
                  (pick < 95) ? $urandom_range(3, 10) : $urandom_range(20, 60);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input logic op_in, input logic [7:0] b, input hint_t hint);
    int unsigned gap;
    int unsigned pick;
    if (calm_left != 0) begin
      calm_left--;
      gap = 0;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 2) calm_left = $urandom_range(40, 150);
      gap = (pick < 65) ? 0 : (pick < 92) ? $urandom_range(1, 3) :
            (pick < 98) ? $urandom_range(4, 10) : $urandom_range(20, 40);
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    op        <= op_in;
    data_byte <= b;
    cur_hint  = hint;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(OP_DATA, b, '0);
    data_items++;
  endtask

  task automatic send_restart();
    send_item(OP_RESTART, 8'($urandom_range(0, 255)), '0);
    gen_run_st = 8'h00;
  endtask

  // Variable-length quantity, most significant group first.
  task automatic send_vlq(input logic [34:0] v, input int unsigned nbytes);
    logic [7:0] b;
    for (int i = nbytes - 1; i >= 0; i--) begin
      b = {(i != 0), 7'(v >> (7 * i))};
      send_byte(b);
    end
  endtask

  task automatic send_delta();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    send_vlq(35'({$urandom(), $urandom()}),
             (pick < 60) ? 1 : (pick < 85) ? 2 : $urandom_range(3, 5));
  endtask

  task automatic send_length(input int unsigned len);
    send_vlq(35'(len), ($urandom_range(0, 4) == 0) ? 2 : 1);
  endtask

  function automatic logic [7:0] param_byte();
    return ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 127))
                                       : 8'($urandom_range(0, 255));
  endfunction

  task automatic send_random_event();
    int unsigned pick;
    int unsigned r;
    int unsigned len;
    logic [7:0]  st;
    logic [7:0]  code;
    pick = $urandom_range(0, 99);
    if (pick < 96) send_delta();
    if (pick < 30) begin
      r = $urandom_range(0, 9);
      if (r < 6) begin
        st = {(r < 3) ? ST_NOTE_OFF[7:4] : ST_NOTE_ON[7:4], 4'($urandom_range(0, 15))};
      end else begin
        do st = 8'($urandom_range(ST_CHAN_MISC, ST_SYS_LAST));
        while (st == ST_SYSEX || st == ST_SYSEX_ESC);
      end
      send_byte(st);
      gen_run_st = st;
      send_byte(param_byte());
      if (!single_param(st)) send_byte(param_byte());
    end else if (pick < 55) begin
      send_byte(8'($urandom_range(0, 127)));
      if (!single_param(gen_run_st)) send_byte(param_byte());
    end else if (pick < 65) begin
      send_byte(($urandom_range(0, 1) != 0) ? ST_SYSEX : ST_SYSEX_ESC);
      len = $urandom_range(0, 6);
      send_length(len);
      repeat (len) send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 80) begin
      send_byte(ST_META);
      send_byte(META_TEMPO);
      len = ($urandom_range(0, 1) != 0) ? 3 : $urandom_range(0, 6);
      send_length(len);
      repeat (len) send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 90) begin
      send_byte(ST_META);
      do code = 8'($urandom_range(0, 127));
      while (code == META_TEMPO || code == META_EOT);
      send_byte(code);
      len = $urandom_range(0, 5);
      send_length(len);
      repeat (len) send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 94) begin
      send_byte(ST_META);
      send_byte(8'($urandom_range(128, 255)));
      send_length($urandom_range(0, 5));
    end else if (pick < 96) begin
      send_byte(ST_META);
      send_byte(META_EOT);
      send_length($urandom_range(0, 3));
      // everything after end of track is dropped by the block
      repeat ($urandom_range(0, 4)) send_item(OP_DATA, 8'($urandom_range(0, 255)), '0);
      send_restart();
    end else if (pick < 98) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      send_restart();
    end else begin
      // event cut short by a restart
      repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
      send_restart();
    end
  endtask

  row_t plan [0:25];

  initial begin
    hint_t h;
    plan = '{
      '{OP_RESTART, 8'hA5, 1, 0, KIND_NOTE,    32'h0,        8'h00, 8'h00, 4'h0, 32'h0},
      '{OP_DATA,    8'h00, 0, 0, KIND_NOTE,    32'h0,        8'h00, 8'h00, 4'h0, 32'h0},
      '{OP_DATA,    8'h05, 0, 0, KIND_NOTE,    32'h0,        8'h00, 8'h00, 4'h0, 32'h0},
      '{OP_DATA,    8'h06, 1, 1, KIND_IGNORED, 32'h0,        8'h00, 8'h00, 4'h0, 32'h0},
      '{OP_DATA,    8'h00, 0, 0, KIND_NOTE,    32'h0,        8'h00, 8'h00, 4'h0, 32'h0},
      '{OP_DATA,    8'h90, 0, 0, KIND_NOTE,    32'h0,        8'h00, 8'h00, 4'h0, 32'h0},
      '{OP_DATA,    8'h00, 0, 0, KIND_NOTE,    32'h0,        8'h00, 8'h00, 4'h0, 32'h0},
      '{OP_DATA,    8'h7F, 1, 1, KIND_NOTE,    32'h0,        8'h00, 8'h7F, 4'h0, 32'h0},
      '{OP_DATA,    8'hFF, 0, 0, KIND_NOTE,    32'h0,        8'h00, 8'h00, 4'h0, 32'h0},
      '{OP_DATA,    8'hFF, 0, 0, KIND_NOTE,    32'h0,        8'h00, 8'h00, 4'h0, 32'h0},
      '{OP_DATA,    8'hFF, 0, 0, KIND_NOTE,    32'h0,        8'h00, 8'h00, 4'h0, 32'h0},
      '{OP_DATA,    8'hFF, 0, 0, KIND_NOTE,    32'h0,        8'h00, 8'h00, 4'h0, 32'h0},
      '{OP_DATA,    8'h7F, 0, 0, KIND_NOTE,    32'h0,        8'h00, 8'h00, 4'h0, 32'h0},
      '{OP_DATA,    8'h8F, 0, 0, KIND_NOTE,    32'h0,        8'h00, 8'h00, 4'h0, 32'h0},
      '{OP_DATA,    8'h7F, 0, 0, KIND_NOTE,    32'h0,        8'h00, 8'h00, 4'h0, 32'h0},
      '{OP_DATA,    8'h64, 1, 1, KIND_NOTE,    32'hFFFFFFFF, 8'h7F, 8'h00, 4'hF, 32'h0},
      '{OP_DATA,    8'h00, 0, 0, KIND_NOTE,    32'h0,        8'h00, 8'h00, 4'h0, 32'h0},
      '{OP_DATA,    8'hFF, 0, 0, KIND_NOTE,    32'h0,        8'h00, 8'h00, 4'h0, 32'h0},
      '{OP_DATA,    8'h51, 0, 0, KIND_NOTE,    32'h0,        8'h00, 8'h00, 4'h0, 32'h0},
      '{OP_DATA,    8'h00, 1, 1, KIND_TEMPO,   32'h0,        8'h00, 8'h00, 4'h0, 32'h0},
      '{OP_DATA,    8'h00, 0, 0, KIND_NOTE,    32'h0,        8'h00, 8'h00, 4'h0, 32'h0},
      '{OP_DATA,    8'hFF, 0, 0, KIND_NOTE,    32'h0,        8'h00, 8'h00, 4'h0, 32'h0},
      '{OP_DATA,    8'h2F, 0, 0, KIND_NOTE,    32'h0,        8'h00, 8'h00, 4'h0, 32'h0},
      '{OP_DATA,    8'h00, 1, 1, KIND_END,     32'h0,        8'h00, 8'h00, 4'h0, 32'h0},
      '{OP_DATA,    8'h90, 1, 0, KIND_NOTE,    32'h0,        8'h00, 8'h00, 4'h0, 32'h0},
      '{OP_RESTART, 8'h5A, 1, 0, KIND_NOTE,    32'h0,        8'h00, 8'h00, 4'h0, 32'h0}
    };
    clear_parser();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan[i]) begin
      h.typed    = plan[i].typed;
      h.has      = plan[i].has;
      h.ev.kind  = plan[i].kind;
      h.ev.delta = plan[i].delta;
      h.ev.note  = plan[i].note;
      h.ev.vel   = plan[i].vel;
      h.ev.chan  = plan[i].chan;
      h.ev.tempo = plan[i].tempo;
      send_item(plan[i].op, plan[i].b, h);
    end
    gen_run_st = 8'h00;

    while (data_items < DATA_ITEMS) send_random_event();
    in_valid <= 1'b0;

    while (pending_events.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(20 * MAX_CYCLES);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
